>>> design/assert_macros.svh
// Assertion macros for the key switch power hold RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/kshp_pkg.sv
// Package for the key switch power hold block: widths, register codes, word types.
package kshp_pkg;

  // Debounce counter width
  localparam int COUNT_WIDTH = 16;

  localparam int T_W      = 15;           // base debounce ticks
  localparam int HOLD_W   = 16;           // fault hold timer
  localparam int THR_W    = 15;           // speed thresholds
  localparam int SPEED_W  = 16;           // signed motor speed
  localparam int MAG_W    = SPEED_W + 1;  // |speed|, covers 32768
  localparam int CEIL_W   = T_W + 2;      // 3T
  localparam int CMP_W    = (COUNT_WIDTH > CEIL_W) ? COUNT_WIDTH : CEIL_W;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_BASE_TICKS   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FAULT_HOLD_TICKS = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_HOLD_HIGH  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_HOLD_LOW   = CFG_INDEX_W'(3);

  // Register reset values
  localparam logic [T_W-1:0]    KEY_BASE_RESET   = T_W'(10);
  localparam logic [HOLD_W-1:0] FAULT_HOLD_RESET = HOLD_W'(20000);
  localparam logic [THR_W-1:0]  SPEED_HIGH_RESET = THR_W'(500);
  localparam logic [THR_W-1:0]  SPEED_LOW_RESET  = THR_W'(450);

  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

  typedef struct packed {
    logic [T_W-1:0]    key_base_ticks;
    logic [HOLD_W-1:0] fault_hold_ticks;
    logic [THR_W-1:0]  speed_hold_high;
    logic [THR_W-1:0]  speed_hold_low;
  } kshp_cfg_t;

  typedef struct packed {
    logic                      key_level;
    logic                      remote_key_on;
    logic                      sensor_fault;
    logic signed [SPEED_W-1:0] motor_speed;
  } kshp_tick_t;

endpackage

>>> design/kshp_debounce.sv
// Key switch up/down debounce counter with hysteresis and remote override.
module kshp_debounce
  import kshp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [T_W-1:0] key_base_ticks,
  input  logic           key_level,
  input  logic           remote_key_on,
  output logic           key_flag_next,
  output logic           key_flag
);

  logic [COUNT_WIDTH-1:0] key_count;
  logic [COUNT_WIDTH-1:0] key_count_next;
  logic [CEIL_W-1:0]      ceil3;
  logic [CMP_W-1:0]       ceiling;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       next_ext;
  logic [CMP_W-1:0]       t1;
  logic [CMP_W-1:0]       t2;

  // Thresholds at full precision; ceiling clipped to the counter range
  always_comb begin
    ceil3 = CEIL_W'({key_base_ticks, 1'b0}) + CEIL_W'(key_base_ticks);
    t1    = CMP_W'(key_base_ticks);
    t2    = CMP_W'({key_base_ticks, 1'b0});
    if (CMP_W'(ceil3) > CMP_W'({COUNT_WIDTH{1'b1}})) begin
      ceiling = CMP_W'({COUNT_WIDTH{1'b1}});
    end else begin
      ceiling = CMP_W'(ceil3);
    end
  end

  // Count one step toward the ceiling or toward zero
  always_comb begin
    count_ext      = CMP_W'(key_count);
    key_count_next = key_count;
    if (key_level) begin
      if (count_ext < ceiling) key_count_next = key_count + COUNT_WIDTH'(1);
    end else begin
      if (key_count != '0) key_count_next = key_count - COUNT_WIDTH'(1);
    end
  end

  // Hysteresis: on at 2T, off at T or below (off wins), remote forces on
  always_comb begin
    next_ext      = CMP_W'(key_count_next);
    key_flag_next = key_flag;
    if (next_ext >= t2) key_flag_next = 1'b1;
    if (next_ext <= t1) key_flag_next = 1'b0;
    if (remote_key_on)  key_flag_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      key_flag  <= 1'b0;
    end else if (step) begin
      key_count <= key_count_next;
      key_flag  <= key_flag_next;
    end
  end

endmodule

>>> design/kshp_power_hold.sv
// Power latch with sensor fault timeout and speed hysteresis band.
module kshp_power_hold
  import kshp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [HOLD_W-1:0]         fault_hold_ticks,
  input  logic [THR_W-1:0]          speed_hold_high,
  input  logic [THR_W-1:0]          speed_hold_low,
  input  logic                      sensor_fault,
  input  logic signed [SPEED_W-1:0] motor_speed,
  input  logic                      key_flag_next,
  output logic                      power_latch
);

  logic [HOLD_W-1:0] hold_count;
  logic [HOLD_W-1:0] hold_count_next;
  logic              power_latch_next;
  logic [MAG_W-1:0]  mag;

  // Speed magnitude; most negative speed maps to 32768
  always_comb begin
    if (motor_speed[SPEED_W-1]) begin
      mag = MAG_W'(0) - {1'b1, motor_speed};
    end else begin
      mag = {1'b0, motor_speed};
    end
  end

  // First matching case decides the latch and the timer
  always_comb begin
    hold_count_next  = hold_count;
    power_latch_next = power_latch;
    if (key_flag_next) begin
      power_latch_next = 1'b1;
      hold_count_next  = '0;
    end else if (sensor_fault) begin
      if (hold_count > fault_hold_ticks) begin
        power_latch_next = 1'b0;
      end else begin
        if (hold_count != HOLD_MAX) hold_count_next = hold_count + HOLD_W'(1);
        power_latch_next = 1'b1;
      end
    end else if (mag > MAG_W'(speed_hold_high)) begin
      power_latch_next = 1'b1;
      hold_count_next  = '0;
    end else if (mag > MAG_W'(speed_hold_low)) begin
      // inside the band: keep as is
      power_latch_next = power_latch;
    end else begin
      power_latch_next = 1'b0;
      hold_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count  <= '0;
      power_latch <= 1'b0;
    end else if (step) begin
      hold_count  <= hold_count_next;
      power_latch <= power_latch_next;
    end
  end

endmodule

>>> design/key_switch_power_hold.sv
// Top level of the key switch debounce and power hold block.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------------
//  in      | in        | in_valid / in_stall  | key_level remote_key_on sensor_fault speed
//  out     | out       | out_valid / out_stall| key_on keep_power
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index cfg_data
//
// One tick word per cycle while the output is not stalled; an accepted tick word
// goes through the input register, then the state/result registers.
// The state registers are the result register.
// Reset (synchronous) clears the counters and flags and loads register defaults.
// An output stall holds the result; the input stalls only once the input
// register is also full. cfg_ready is always high.
`include "assert_macros.svh"

module key_switch_power_hold
  import kshp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      key_level,
  input  logic                      remote_key_on,
  input  logic                      sensor_fault,
  input  logic signed [SPEED_W-1:0] motor_speed,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      key_on,
  output logic                      keep_power,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  kshp_cfg_t  cfg;
  kshp_tick_t tick;
  logic       tick_valid;
  logic       step;
  logic       key_flag_next;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_base_ticks   <= KEY_BASE_RESET;
      cfg.fault_hold_ticks <= FAULT_HOLD_RESET;
      cfg.speed_hold_high  <= SPEED_HIGH_RESET;
      cfg.speed_hold_low   <= SPEED_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_BASE_TICKS:   cfg.key_base_ticks   <= cfg_data[T_W-1:0];
        REG_FAULT_HOLD_TICKS: cfg.fault_hold_ticks <= cfg_data[HOLD_W-1:0];
        REG_SPEED_HOLD_HIGH:  cfg.speed_hold_high  <= cfg_data[THR_W-1:0];
        REG_SPEED_HOLD_LOW:   cfg.speed_hold_low   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a tick moves into the result when the output slot frees up
  assign step     = tick_valid && (!out_valid || !out_stall);
  assign in_stall = tick_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tick_valid <= 1'b1;
      end else if (step) begin
        tick_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick.key_level     <= key_level;
      tick.remote_key_on <= remote_key_on;
      tick.sensor_fault  <= sensor_fault;
      tick.motor_speed   <= motor_speed;
    end
  end

  kshp_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .key_base_ticks (cfg.key_base_ticks),
    .key_level      (tick.key_level),
    .remote_key_on  (tick.remote_key_on),
    .key_flag_next  (key_flag_next),
    .key_flag       (key_on)
  );

  kshp_power_hold u_power_hold (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .fault_hold_ticks (cfg.fault_hold_ticks),
    .speed_hold_high  (cfg.speed_hold_high),
    .speed_hold_low   (cfg.speed_hold_low),
    .sensor_fault     (tick.sensor_fault),
    .motor_speed      (tick.motor_speed),
    .key_flag_next    (key_flag_next),
    .power_latch      (keep_power)
  );

  // Checks
  `ASSERT_CLK(a_key_holds_power, clk, rst, key_on |-> keep_power, "key on without power held")
  `ASSERT_CLK_ALWAYS(a_stall_only_full, clk, in_stall |-> tick_valid && out_valid, "input stalled with room")
  `ASSERT_CLK(a_step_gives_result, clk, rst, step |=> out_valid, "tick step lost its result")
  `ASSERT_CLK(a_state_holds, clk, rst, !step |=> $stable(key_on) && $stable(keep_power), "state moved without a tick")

endmodule

>>> dv/testbench.sv
// Testbench for the key switch debounce and power hold block, with its own tick predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kshp_pkg::*;

  // Write to an index that has no register; the block must ignore it
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(165);
  localparam int PHASES      = 12;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYC  = 4;

  typedef struct packed {
    logic key_on;
    logic keep_power;
  } power_word_t;

  // Tracks debounce and power hold state, queues the expected output words
  class hold_tracker;
    logic [T_W-1:0]    base_ticks;
    logic [HOLD_W-1:0] fault_ticks;
    logic [THR_W-1:0]  high_thr;
    logic [THR_W-1:0]  low_thr;
    longint            key_count;
    bit                key_flag;
    int                hold_count;
    bit                power_latch;
    power_word_t       expected_words[$];
    int                mismatches;

    function new();
      base_ticks  = KEY_BASE_RESET;
      fault_ticks = FAULT_HOLD_RESET;
      high_thr    = SPEED_HIGH_RESET;
      low_thr     = SPEED_LOW_RESET;
      key_count   = 0;
      key_flag    = 1'b0;
      hold_count  = 0;
      power_latch = 1'b0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KEY_BASE_TICKS:   base_ticks  = data[T_W-1:0];
        REG_FAULT_HOLD_TICKS: fault_ticks = data[HOLD_W-1:0];
        REG_SPEED_HOLD_HIGH:  high_thr    = data[THR_W-1:0];
        REG_SPEED_HOLD_LOW:   low_thr     = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance one tick and queue the resulting word
    function void note_tick(kshp_tick_t t);
      longint t1;
      longint ceiling;
      longint cnt_max;
      int     mag;
      t1      = base_ticks;
      ceiling = 3 * t1;
      cnt_max = (longint'(1) << COUNT_WIDTH) - 1;
      if (ceiling > cnt_max) ceiling = cnt_max;

      // up/down debounce counter, saturating at the ceiling and at zero
      if (t.key_level) begin
        if (key_count < ceiling) key_count++;
      end else if (key_count > 0) begin
        key_count--;
      end

      // hysteresis: on at 2T, off at T (off wins when both hold)
      if (key_count >= 2 * t1) key_flag = 1'b1;
      if (key_count <= t1) key_flag = 1'b0;
      if (t.remote_key_on) key_flag = 1'b1;

      mag = int'($signed(t.motor_speed));
      if (mag < 0) mag = -mag;

      // power latch decision, first matching case wins
      if (key_flag) begin
        power_latch = 1'b1;
        hold_count  = 0;
      end else if (t.sensor_fault) begin
        if (hold_count > fault_ticks) begin
          power_latch = 1'b0;
        end else begin
          if (hold_count < HOLD_MAX) hold_count++;
          power_latch = 1'b1;
        end
      end else if (mag > high_thr) begin
        power_latch = 1'b1;
        hold_count  = 0;
      end else if (mag > low_thr) begin
        // band between thresholds: latch keeps its value
      end else begin
        power_latch = 1'b0;
        hold_count  = 0;
      end
      expected_words.push_back('{key_flag, power_latch});
    endfunction

    function void check_word(logic key_on, logic keep_power);
      power_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected word key_on=%b keep_power=%b", $realtime, key_on, keep_power);
        return;
      end
      want = expected_words.pop_front();
      if (key_on !== want.key_on || keep_power !== want.keep_power) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch key_on exp %b got %b, keep_power exp %b got %b",
                   $realtime, want.key_on, key_on, want.keep_power, keep_power);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  logic                      key_level     = 1'b0;
  logic                      remote_key_on = 1'b0;
  logic                      sensor_fault  = 1'b0;
  logic signed [SPEED_W-1:0] motor_speed   = '0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  logic                      key_on;
  logic                      keep_power;
  logic                      cfg_valid     = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index     = '0;
  logic [CFG_DATA_W-1:0]     cfg_data      = '0;

  hold_tracker tracker;

  // current register values, used to aim the stimulus
  int cfg_t     = KEY_BASE_RESET;
  int cfg_fault = FAULT_HOLD_RESET;
  int cfg_high  = SPEED_HIGH_RESET;
  int cfg_low   = SPEED_LOW_RESET;

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  key_switch_power_hold uut (.*);

  always #5 clk = ~clk;

  // Monitor: note accepted tick words, check accepted output words
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        tracker.note_tick('{key_level, remote_key_on, sensor_fault, motor_speed});
      if (out_valid && !out_stall)
        tracker.check_word(key_on, keep_power);
    end
  end

  // Output stall: modes from none to heavy, switched when each mode's random run ends
  always @(posedge clk) begin
    logic s;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       s = 1'b0;
      1:       s = ($urandom_range(0, 3) == 0);
      2:       s = ($urandom_range(0, 3) != 0);
      default: s = ((stall_left % 6) < 2);
    endcase
    out_stall <= rst ? 1'b0 : s;
  end

  // Send one tick word; bursts of random length with random gaps between
  task automatic send_tick(kshp_tick_t t);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    key_level     <= t.key_level;
    remote_key_on <= t.remote_key_on;
    sensor_fault  <= t.sensor_fault;
    motor_speed   <= t.motor_speed;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
  endtask

  // Program all four registers; 15-bit registers get a random unused top bit
  task automatic program_regs(int t, int f, int h, int l, bit poke);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom_range(0, 1)) << T_W;
    write_reg(REG_KEY_BASE_TICKS, CFG_DATA_W'(t) | junk);
    write_reg(REG_FAULT_HOLD_TICKS, CFG_DATA_W'(f));
    junk = CFG_DATA_W'($urandom_range(0, 1)) << THR_W;
    write_reg(REG_SPEED_HOLD_HIGH, CFG_DATA_W'(h) | junk);
    junk = CFG_DATA_W'($urandom_range(0, 1)) << THR_W;
    write_reg(REG_SPEED_HOLD_LOW, CFG_DATA_W'(l) | junk);
    if (poke) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
    cfg_t     = t;
    cfg_fault = f;
    cfg_high  = h;
    cfg_low   = l;
  endtask

  // Wait for every expected word, then let the pipeline empty
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      guard++;
    end while (tracker.pending() != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic kshp_tick_t make_tick(bit k, bit r, bit f, int speed);
    kshp_tick_t t;
    t.key_level     = k;
    t.remote_key_on = r;
    t.sensor_fault  = f;
    t.motor_speed   = SPEED_W'(speed);
    return t;
  endfunction

  // Speeds mostly near the thresholds, plus full-range and extreme values
  function automatic logic signed [SPEED_W-1:0] pick_speed();
    int v;
    int d;
    d = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 7))
      0:       v = int'($urandom());
      1:       v = cfg_high + d;
      2:       v = cfg_low + d;
      3:       v = -(cfg_high + d);
      4:       v = -(cfg_low + d);
      5:       v = (cfg_low < cfg_high) ? int'($urandom_range(cfg_low, cfg_high)) : cfg_low;
      6:       v = $urandom_range(0, 1) ? -32768 : 32767;
      default: v = int'($urandom_range(0, 20)) - 10;
    endcase
    return SPEED_W'(v);
  endfunction

  // Random ticks: key level and fault in runs, with single-tick glitches
  task automatic run_ticks(int count);
    int         key_run;
    int         fault_run;
    int         key_cap;
    int         fault_cap;
    bit         lvl;
    bit         flt;
    kshp_tick_t t;
    key_run   = 0;
    fault_run = 0;
    lvl       = 1'b0;
    flt       = 1'b0;
    key_cap   = (4 * cfg_t + 4 > 60) ? 60 : 4 * cfg_t + 4;
    fault_cap = (cfg_fault + 10 > 80) ? 80 : cfg_fault + 10;
    repeat (count) begin
      if (key_run == 0) begin
        lvl     = !lvl;
        key_run = $urandom_range(1, key_cap);
      end
      if (fault_run == 0) begin
        flt       = ($urandom_range(0, 2) == 0);
        fault_run = flt ? $urandom_range(1, fault_cap) : $urandom_range(1, 40);
      end
      t.key_level     = lvl ^ ($urandom_range(0, 15) == 0);
      t.remote_key_on = ($urandom_range(0, 15) == 0);
      t.sensor_fault  = flt ^ ($urandom_range(0, 31) == 0);
      t.motor_speed   = pick_speed();
      send_tick(t);
      key_run--;
      fault_run--;
    end
  endtask

  initial begin
    int t;
    int f;
    int h;
    int l;
    int n;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at reset settings: speed edges, fault, remote request
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 501));
    send_tick(make_tick(0, 0, 0, 500));
    send_tick(make_tick(0, 0, 0, 451));
    send_tick(make_tick(0, 0, 0, 450));
    send_tick(make_tick(0, 0, 0, -32768));
    send_tick(make_tick(0, 0, 0, -451));
    send_tick(make_tick(0, 0, 0, -450));
    send_tick(make_tick(0, 0, 0, 32767));
    send_tick(make_tick(0, 0, 0, -501));
    send_tick(make_tick(0, 0, 1, 0));
    send_tick(make_tick(0, 0, 1, -32768));
    send_tick(make_tick(0, 1, 0, 0));
    send_tick(make_tick(1, 0, 1, 0));
    send_tick(make_tick(1, 1, 0, -1));
    send_tick(make_tick(0, 0, 0, 450));
    send_tick(make_tick(0, 0, 0, -1));
    settle();

    // Phases: minimum values, zero base with full fault hold and max thresholds,
    // crossed thresholds, oversized ceilings, then random small settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin t = 1; f = 0; h = 0; l = 0; n = 150; end
        1: begin t = 0; f = 65535; h = 32767; l = 32767; n = 150; end
        2: begin t = 3; f = 4; h = 100; l = 300; n = 150; end
        3: begin t = 32767; f = 12; h = 2000; l = 1000; n = 100; end
        4: begin t = 21845; f = 65534; h = 500; l = 450; n = 50; end
        default: begin
          t = $urandom_range(1, 6);
          f = $urandom_range(0, 40);
          h = $urandom_range(0, 1000);
          l = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, h);
          n = 150;
        end
      endcase
      program_regs(t, f, h, l, p == 2);
      run_ticks(n);
      settle();
    end

    if (tracker.pending() != 0) begin
      $display("%0d expected words never arrived", tracker.pending());
      tracker.mismatches += tracker.pending();
    end
    if (tracker.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
